// ===== src/idod_pkg.sv =====
// Shared types and constants for the input debouncer with on and off delay.
package idod_pkg;

    localparam int FIELD_W        = 8;
    localparam int FILTER_W       = 8;
    localparam int HOLD_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int NUM_INPUTS_DEF = 8;

    localparam logic [FILTER_W-1:0] FILTER_RESET = FILTER_W'(20);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_HOLD_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD_TICKS = 2'd2;

    typedef struct packed {
        logic [FILTER_W-1:0] filter_samples;
        logic [HOLD_W-1:0]   on_hold_ticks;
        logic [HOLD_W-1:0]   off_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic debounced;
        logic filtered;
    } lane_res_t;

endpackage

// ===== src/idod_if.sv =====
// Handshake channel interfaces for samples, results and configuration writes.
interface idod_in_if
    import idod_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

interface idod_out_if
    import idod_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] debounced_levels;
    logic [FIELD_W-1:0] filtered_levels;

    modport source (output valid, output debounced_levels, output filtered_levels,
                    input ready);
    modport sink   (input valid, input debounced_levels, input filtered_levels,
                    output ready);
endinterface

interface idod_cfg_if
    import idod_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/idod_lane.sv =====
// One channel: on/off sample counters, filtered level and hold timer.
module idod_lane
    import idod_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      level,
    input  cfg_t      cfg,
    output lane_res_t res
);

    logic [FILTER_W-1:0] on_count_reg;
    logic [FILTER_W-1:0] on_count_next;
    logic [FILTER_W-1:0] off_count_reg;
    logic [FILTER_W-1:0] off_count_next;
    logic                filtered_reg;
    logic                filtered_next;
    logic                debounced_reg;
    logic                debounced_next;
    logic [HOLD_W-1:0]   hold_count_reg;
    logic [HOLD_W-1:0]   hold_count_next;

    logic [FILTER_W-1:0] on_inc;
    logic [FILTER_W-1:0] off_inc;
    logic [HOLD_W-1:0]   hold_inc;
    logic [HOLD_W-1:0]   hold_limit;

    always_comb
    begin
        on_inc   = (on_count_reg == '1) ? on_count_reg : on_count_reg + 1'b1;
        off_inc  = (off_count_reg == '1) ? off_count_reg : off_count_reg + 1'b1;
        hold_inc = (hold_count_reg == '1) ? hold_count_reg : hold_count_reg + 1'b1;

        on_count_next   = on_count_reg;
        off_count_next  = off_count_reg;
        filtered_next   = filtered_reg;
        debounced_next  = debounced_reg;
        hold_count_next = hold_count_reg;

        // Below the threshold, a sample counts up its own counter and leaves the other alone.
        if (level)
        begin
            if (on_inc > cfg.filter_samples)
            begin
                on_count_next  = '0;
                off_count_next = '0;
                filtered_next  = 1'b1;
            end
            else
            begin
                on_count_next = on_inc;
            end
        end
        else
        begin
            if (off_inc > cfg.filter_samples)
            begin
                on_count_next  = '0;
                off_count_next = '0;
                filtered_next  = 1'b0;
            end
            else
            begin
                off_count_next = off_inc;
            end
        end

        hold_limit = filtered_next ? cfg.on_hold_ticks : cfg.off_hold_ticks;

        if (filtered_next == debounced_reg)
        begin
            hold_count_next = '0;
        end
        else if (hold_inc >= hold_limit)
        begin
            debounced_next  = filtered_next;
            hold_count_next = '0;
        end
        else
        begin
            hold_count_next = hold_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_count_reg   <= '0;
            off_count_reg  <= '0;
            filtered_reg   <= 1'b0;
            debounced_reg  <= 1'b0;
            hold_count_reg <= '0;
        end
        else if (advance)
        begin
            on_count_reg   <= on_count_next;
            off_count_reg  <= off_count_next;
            filtered_reg   <= filtered_next;
            debounced_reg  <= debounced_next;
            hold_count_reg <= hold_count_next;
        end
    end

    assign res.debounced = debounced_next;
    assign res.filtered  = filtered_next;

endmodule

// ===== src/idod_merge.sv =====
// Packs the lane results into one result word and holds it in the output register.
module idod_merge
    import idod_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lane_res_t         res [NUM_INPUTS],
    output logic              space,
    idod_out_if.source        result
);

    logic               valid_reg;
    logic               valid_next;
    logic [FIELD_W-1:0] deb_reg;
    logic [FIELD_W-1:0] fil_reg;
    logic [FIELD_W-1:0] deb_word;
    logic [FIELD_W-1:0] fil_word;

    // Channels past the field width never show; bits past the channel count read off.
    for (genvar i = 0; i < FIELD_W; i++)
    begin : g_bit
        if (i < NUM_INPUTS)
        begin : g_used
            assign deb_word[i] = res[i].debounced;
            assign fil_word[i] = res[i].filtered;
        end
        else
        begin : g_unused
            assign deb_word[i] = 1'b0;
            assign fil_word[i] = 1'b0;
        end
    end

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            deb_reg <= deb_word;
            fil_reg <= fil_word;
        end
    end

    assign result.valid            = valid_reg;
    assign result.debounced_levels = deb_reg;
    assign result.filtered_levels  = fil_reg;

endmodule

// ===== src/input_debounce_on_off_delay.sv =====
// Top level of the multi-channel input debouncer with on and off delay.
//
//  channel  dir  word                                    handshake
//  sample   in   raw_levels[7:0]                         valid/ready
//  result   out  debounced_levels[7:0], filtered_levels  valid/ready
//  cfg      in   index[1:0], data[15:0]                  valid/ready, always ready
//
// One sample word per cycle; its result is in the output register in the cycle
// after acceptance. All channel lanes update in parallel on acceptance.
// A sample is taken while the output register is empty or being drained, so a
// stalled result stops intake. Reset clears all channel state and loads the
// default register values; no clearing pass is needed.
module input_debounce_on_off_delay
    import idod_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    idod_in_if.sink    sample,
    idod_out_if.source result,
    idod_cfg_if.sink   cfg
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      space;
    logic      advance;
    lane_res_t res [NUM_INPUTS];

    assign cfg.ready    = 1'b1;
    assign sample.ready = space;
    assign advance      = sample.valid && space;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FILTER_SAMPLES: cfg_next.filter_samples = cfg.data[FILTER_W-1:0];
                CFG_ON_HOLD_TICKS:  cfg_next.on_hold_ticks  = cfg.data[HOLD_W-1:0];
                CFG_OFF_HOLD_TICKS: cfg_next.off_hold_ticks = cfg.data[HOLD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_samples <= FILTER_RESET;
            cfg_reg.on_hold_ticks  <= '0;
            cfg_reg.off_hold_ticks <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    for (genvar i = 0; i < NUM_INPUTS; i++)
    begin : g_lane
        logic level;

        if (i < FIELD_W)
        begin : g_in
            assign level = sample.raw_levels[i];
        end
        else
        begin : g_off
            assign level = 1'b0;
        end

        idod_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .level   (level),
            .cfg     (cfg_reg),
            .res     (res[i])
        );
    end

    idod_merge #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule

// ===== src/idod_checker.sv =====
// Port-level checks for the debouncer, attached to the top level by bind.
module idod_checker
    import idod_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] out_deb,
    input logic [FIELD_W-1:0] out_fil,
    input logic               cfg_ready
);

    // An accepted sample always leaves a result word behind in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted sample produced no result word");

    // Intake must stop while a result word sits stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample taken while result word is stalled");

    // Without a new sample, a drained output stays empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("result word repeated without a new sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_deb) && $stable(out_fil))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind input_debounce_on_off_delay idod_checker u_idod_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_deb   (result.debounced_levels),
    .out_fil   (result.filtered_levels),
    .cfg_ready (cfg.ready)
);
